>>> rtl/core/qrm_pkg.sv
// Package for the quaternion to rotation matrix core: widths, payload and lane types.
package qrm_pkg;

    // Component width of the Q1.x payload fields
    localparam int QRM_CW = 16;
    // Default fraction bits
    localparam int QRM_FRAC_BITS = 14;
    // Width of sums of products and of the divider remainder
    localparam int QRM_NW = 2 * QRM_CW + 2;
    // Number of matrix entries produced
    localparam int QRM_NLANE = 9;

    typedef struct packed {
        logic signed [QRM_CW-1:0] comp_w;
        logic signed [QRM_CW-1:0] comp_x;
        logic signed [QRM_CW-1:0] comp_y;
        logic signed [QRM_CW-1:0] comp_z;
    } t_qrm_in;

    typedef struct packed {
        logic signed [QRM_CW-1:0] entry_0;
        logic signed [QRM_CW-1:0] entry_1;
        logic signed [QRM_CW-1:0] entry_2;
        logic signed [QRM_CW-1:0] entry_4;
        logic signed [QRM_CW-1:0] entry_5;
        logic signed [QRM_CW-1:0] entry_6;
        logic signed [QRM_CW-1:0] entry_8;
        logic signed [QRM_CW-1:0] entry_9;
        logic signed [QRM_CW-1:0] entry_10;
        logic                     zero_quat;
    } t_qrm_out;

    // One numerator on its way into a divider lane
    typedef struct packed {
        logic              neg;
        logic              sat;
        logic [QRM_NW-1:0] mag;
    } t_qrm_lane;

endpackage

>>> rtl/core/quaternion_to_rotation_matrix_core.sv
// Top level: quaternion to 3x3 rotation matrix, Q1.x fixed point, pipelined.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+---------------------------------
//  in      | i_valid  | o_stall  | i_item (w, x, y, z)
//  out     | o_valid  | i_stall  | o_item (nine entries, zero_quat)
//
// FRAC_BITS + 5 register stages (19 by default): three front stages for the products
// and sums, one divider stage per quotient bit, and the output register. One item
// is taken every cycle while o_stall is low. Reset clears the valid bits only.
// Each stage holds while the stage after it is full and held, so empty stages
// still fill while the output waits.
module quaternion_to_rotation_matrix_core
    import qrm_pkg::*;
#(
    parameter int FRAC_BITS = QRM_FRAC_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_qrm_in  i_item,
    output logic     o_valid,
    input  logic     i_stall,
    output t_qrm_out o_item
);

    localparam int NDIV = FRAC_BITS + 1;
    localparam int NST  = NDIV + 4;
    localparam int ZD   = NDIV + 1;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] rdy;

    // Per-stage advance: a stage loads when it is empty or its successor moves
    always_comb begin
        rdy[NST-1] = !r_vld[NST-1] || !i_stall;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NST-1];

    // Front end
    t_qrm_lane [QRM_NLANE-1:0] lane;
    logic [QRM_NW-1:0]         den;
    logic                      zero;

    qrm_front u_front (
        .i_clk  (i_clk),
        .i_en   (rdy[2:0]),
        .i_item (i_item),
        .o_lane (lane),
        .o_den  (den),
        .o_zero (zero)
    );

    // Divider lanes
    logic signed [QRM_CW-1:0] ent [QRM_NLANE];

    genvar g;
    generate
        for (g = 0; g < QRM_NLANE; g++) begin : g_lane
            qrm_div #(
                .FRAC_BITS (FRAC_BITS)
            ) u_div (
                .i_clk   (i_clk),
                .i_en    (rdy[NDIV+2:3]),
                .i_lane  (lane[g]),
                .i_den   (den),
                .o_entry (ent[g])
            );
        end
    endgenerate

    // Zero flag rides alongside the divider stages
    logic r_zd [ZD];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ZD; k++) begin
            if (rdy[k+3]) begin
                r_zd[k] <= (k == 0) ? zero : r_zd[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Output register, identity for a zero quaternion
    logic [QRM_CW-1:0] one;
    t_qrm_out          n_item, r_item;

    always_comb begin
        one = QRM_CW'(1) << FRAC_BITS;
        if (r_zd[NDIV-1]) begin
            n_item.entry_0  = one;
            n_item.entry_1  = '0;
            n_item.entry_2  = '0;
            n_item.entry_4  = '0;
            n_item.entry_5  = one;
            n_item.entry_6  = '0;
            n_item.entry_8  = '0;
            n_item.entry_9  = '0;
            n_item.entry_10 = one;
        end else begin
            n_item.entry_0  = ent[0];
            n_item.entry_1  = ent[1];
            n_item.entry_2  = ent[2];
            n_item.entry_4  = ent[3];
            n_item.entry_5  = ent[4];
            n_item.entry_6  = ent[5];
            n_item.entry_8  = ent[6];
            n_item.entry_9  = ent[7];
            n_item.entry_10 = ent[8];
        end
        n_item.zero_quat = r_zd[NDIV-1];
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NST-1]) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

>>> rtl/core/qrm_front.sv
// Front end: products, numerator and denominator sums, magnitudes (three stages).
module qrm_front
    import qrm_pkg::*;
(
    input  logic                            i_clk,
    input  logic [2:0]                      i_en,
    input  t_qrm_in                         i_item,
    output t_qrm_lane [QRM_NLANE-1:0]       o_lane,
    output logic [QRM_NW-1:0]               o_den,
    output logic                            o_zero
);

    localparam int PW = 2 * QRM_CW;

    // Stage 0: all ten products
    logic signed [PW-1:0] r_w2, r_x2, r_y2, r_z2;
    logic signed [PW-1:0] r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_w2 <= i_item.comp_w * i_item.comp_w;
            r_x2 <= i_item.comp_x * i_item.comp_x;
            r_y2 <= i_item.comp_y * i_item.comp_y;
            r_z2 <= i_item.comp_z * i_item.comp_z;
            r_xy <= i_item.comp_x * i_item.comp_y;
            r_zw <= i_item.comp_z * i_item.comp_w;
            r_xz <= i_item.comp_x * i_item.comp_z;
            r_yw <= i_item.comp_y * i_item.comp_w;
            r_yz <= i_item.comp_y * i_item.comp_z;
            r_xw <= i_item.comp_x * i_item.comp_w;
        end
    end

    // Stage 1: signed numerators and the squared norm
    logic signed [QRM_NW-1:0] w2, x2, y2, z2, xy, zw, xz, yw, yz, xw;
    logic signed [QRM_NW-1:0] n_num [QRM_NLANE];
    logic signed [QRM_NW-1:0] r_num [QRM_NLANE];
    logic signed [QRM_NW-1:0] r_den1;

    always_comb begin
        w2 = QRM_NW'(r_w2); x2 = QRM_NW'(r_x2);
        y2 = QRM_NW'(r_y2); z2 = QRM_NW'(r_z2);
        xy = QRM_NW'(r_xy); zw = QRM_NW'(r_zw);
        xz = QRM_NW'(r_xz); yw = QRM_NW'(r_yw);
        yz = QRM_NW'(r_yz); xw = QRM_NW'(r_xw);
        n_num[0] = w2 + x2 - y2 - z2;
        n_num[1] = (xy - zw) <<< 1;
        n_num[2] = (xz + yw) <<< 1;
        n_num[3] = (xy + zw) <<< 1;
        n_num[4] = w2 + y2 - x2 - z2;
        n_num[5] = (yz - xw) <<< 1;
        n_num[6] = (xz - yw) <<< 1;
        n_num[7] = (yz + xw) <<< 1;
        n_num[8] = w2 + z2 - x2 - y2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_num  <= n_num;
            r_den1 <= w2 + x2 + y2 + z2;
        end
    end

    // Stage 2: sign and magnitude, saturation check
    t_qrm_lane n_lane [QRM_NLANE];
    t_qrm_lane r_lane [QRM_NLANE];
    logic [QRM_NW-1:0] r_den2;
    logic              r_zero;

    always_comb begin
        for (int k = 0; k < QRM_NLANE; k++) begin
            n_lane[k].neg = r_num[k][QRM_NW-1];
            n_lane[k].mag = r_num[k][QRM_NW-1] ? QRM_NW'(-r_num[k]) : QRM_NW'(r_num[k]);
            n_lane[k].sat = n_lane[k].mag >= QRM_NW'(r_den1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_lane <= n_lane;
            r_den2 <= QRM_NW'(r_den1);
            r_zero <= (r_den1 == '0);
        end
    end

    always_comb begin
        for (int k = 0; k < QRM_NLANE; k++) begin
            o_lane[k] = r_lane[k];
        end
    end

    assign o_den  = r_den2;
    assign o_zero = r_zero;

endmodule

>>> rtl/core/qrm_div.sv
// One divider lane: one restoring quotient bit per stage, then rounding.
module qrm_div
    import qrm_pkg::*;
#(
    parameter int FRAC_BITS = QRM_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic [FRAC_BITS:0]         i_en,
    input  t_qrm_lane                  i_lane,
    input  logic [QRM_NW-1:0]          i_den,
    output logic signed [QRM_CW-1:0]   o_entry
);

    localparam int NS = FRAC_BITS + 1;
    localparam int MW = (QRM_CW > NS) ? QRM_CW : NS;

    logic [QRM_NW-1:0] r_rem [NS];
    logic [QRM_NW-1:0] r_den [NS];
    logic [NS-1:0]     r_q   [NS];
    logic              r_neg [NS];
    logic              r_sat [NS];

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_step
            logic [QRM_NW-1:0] p_rem, p_den, sh;
            logic [NS-1:0]     p_q;
            logic              p_neg, p_sat, ge;

            // Pick up the previous stage
            if (g == 0) begin : g_first
                assign p_rem = i_lane.mag;
                assign p_den = i_den;
                assign p_q   = '0;
                assign p_neg = i_lane.neg;
                assign p_sat = i_lane.sat;
            end else begin : g_next
                assign p_rem = r_rem[g-1];
                assign p_den = r_den[g-1];
                assign p_q   = r_q[g-1];
                assign p_neg = r_neg[g-1];
                assign p_sat = r_sat[g-1];
            end

            // Shift, compare, subtract
            assign sh = {p_rem[QRM_NW-2:0], 1'b0};
            assign ge = sh >= p_den;

            always_ff @(posedge i_clk) begin
                if (i_en[g]) begin
                    r_rem[g] <= ge ? sh - p_den : sh;
                    r_den[g] <= p_den;
                    r_q[g]   <= {p_q[NS-2:0], ge};
                    r_neg[g] <= p_neg;
                    r_sat[g] <= p_sat;
                end
            end
        end
    endgenerate

    // Round half away from zero, saturate to 1.0, apply sign
    logic [NS:0]    q_inc;
    logic [NS-1:0]  mag;
    logic [MW-1:0]  mext, res;

    always_comb begin
        q_inc = {1'b0, r_q[NS-1]} + (NS+1)'(1);
        mag   = r_sat[NS-1] ? (NS'(1) << FRAC_BITS) : q_inc[NS:1];
        mext  = MW'(mag);
        res   = r_neg[NS-1] ? MW'(-mext) : mext;
    end

    assign o_entry = res[QRM_CW-1:0];

endmodule
